// File: design/wrsi_pkg.sv
// Package for the Wilder RSI indicator unit.
// Holds the sequencer state type and the fixed constants; no dependencies.
`default_nettype none

package wrsi_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP_G,
		ST_DIV_G,
		ST_PREP_L,
		ST_DIV_L,
		ST_PREP_R,
		ST_DIV_R,
		ST_OUTPUT
	} wrsi_state_t;

	localparam int PRICE_W   = 32;
	localparam int AVG_W     = 48;
	localparam int DVD_W     = 64;
	localparam int REM_W     = 49;
	localparam int RSI_W     = 14;
	localparam int COUNT_W   = 9;
	localparam int PERIOD_W  = 8;
	localparam int STEP_W    = 7;

	localparam logic [RSI_W-1:0]    RSI_FULL       = 14'd10000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 8'd14;
	localparam logic [STEP_W-1:0]   PERIOD_STEPS   = 7'd64;
	localparam logic [STEP_W-1:0]   RATIO_STEPS    = 7'd14;
	localparam logic                REG_PERIOD     = 1'b0;

endpackage

`default_nettype wire

// File: design/wilder_rsi_indicator_unit.sv
// Wilder RSI indicator unit: one price transfer in, one RSI transfer out.
// Warm-up samples go straight to the output; other samples run the two smoothing divisions,
// then the ratio division, skipped when the average loss is zero; out_ready can stall output.
// Two 64-step divisions by the period and a 14-step ratio division share one
// restoring divider; one sample is in flight at a time. Depends on wrsi_pkg.
// Reset clears the price, averages and sample count; the period resets to 14.
`default_nettype none

module wilder_rsi_indicator_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [wrsi_pkg::PRICE_W-1:0]   price,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [wrsi_pkg::RSI_W-1:0]     rsi_hundredths,
	output logic                                rsi_valid
);
	import wrsi_pkg::*;

	wrsi_state_t state_q, state_d;

	logic [PERIOD_W-1:0] period_q;
	logic [PRICE_W-1:0]  last_price_q;
	logic [AVG_W-1:0]    gain_q, loss_q;
	logic [COUNT_W-1:0]  ss_q;
	logic                first_q;
	logic [PRICE_W-1:0]  up_q, down_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [REM_W-1:0]    rem_q, div_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [RSI_W-1:0]    res_rsi_q;
	logic                res_valid_q;
	logic                out_valid_q;
	logic [RSI_W-1:0]    rsi_out_q;
	logic                rsi_valid_out_q;

	logic [PERIOD_W-1:0] p_eff, p_m1;
	logic [COUNT_W-1:0]  p9;
	logic [PRICE_W-1:0]  up, down;
	logic                cfg_write;
	logic                out_free;

	logic [AVG_W-1:0]    avg_sel;
	logic [PRICE_W-1:0]  chg_sel;
	logic [55:0]         smooth_prod;
	logic [DVD_W-1:0]    smooth_dvd, first_dvd;
	logic [61:0]         rsi_prod;
	logic [REM_W-1:0]    rsi_sum;

	logic [REM_W:0]      shifted, trial;
	logic                take;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_PERIOD) ? {24'd0, period_q} : 32'd0;

	assign p_eff = (period_q == '0) ? 8'd1 : period_q;
	assign p_m1  = p_eff - 8'd1;
	assign p9    = {1'b0, p_eff};

	assign up   = (price >= last_price_q) ? price - last_price_q : '0;
	assign down = (price >= last_price_q) ? '0 : last_price_q - price;

	assign avg_sel     = (state_q == ST_PREP_L) ? loss_q : gain_q;
	assign chg_sel     = (state_q == ST_PREP_L) ? down_q : up_q;
	assign smooth_prod = 56'(avg_sel) * 56'(p_m1);
	assign smooth_dvd  = {8'd0, smooth_prod} + {16'd0, chg_sel, 16'd0};
	assign first_dvd   = {avg_sel, 16'd0};
	assign rsi_prod    = 62'(gain_q) * 62'(RSI_FULL);
	assign rsi_sum     = {1'b0, gain_q} + {1'b0, loss_q};

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign take    = shifted >= {1'b0, div_q};
	assign trial   = shifted - {1'b0, div_q};

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign rsi_hundredths = rsi_out_q;
	assign rsi_valid      = rsi_valid_out_q;
	assign out_free       = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (ss_q == '0 || (ss_q < p9))
						state_d = ST_OUTPUT;
					else
						state_d = ST_PREP_G;
				end
			end
			ST_PREP_G: state_d = ST_DIV_G;
			ST_DIV_G:  if (cnt_q == '0) state_d = ST_PREP_L;
			ST_PREP_L: state_d = ST_DIV_L;
			ST_DIV_L:  if (cnt_q == '0) state_d = ST_PREP_R;
			ST_PREP_R: state_d = (loss_q == '0) ? ST_OUTPUT : ST_DIV_R;
			ST_DIV_R:  if (cnt_q == '0) state_d = ST_OUTPUT;
			ST_OUTPUT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RESET;
			last_price_q <= '0;
			gain_q       <= '0;
			loss_q       <= '0;
			ss_q         <= '0;
			first_q      <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_write && paddr[2] == REG_PERIOD)
				period_q <= pwdata[PERIOD_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_price_q <= price;
						if (ss_q == '0) begin
							ss_q <= 9'd1;
						end else if (ss_q <= p9) begin
							gain_q  <= gain_q + AVG_W'(up);
							loss_q  <= loss_q + AVG_W'(down);
							ss_q    <= ss_q + 9'd1;
							first_q <= 1'b1;
						end else begin
							ss_q    <= p9 + 9'd1;
							first_q <= 1'b0;
						end
					end
				end
				ST_PREP_G, ST_PREP_L: begin
					cnt_q <= PERIOD_STEPS;
				end
				ST_PREP_R: begin
					cnt_q <= RATIO_STEPS;
				end
				ST_DIV_G, ST_DIV_L, ST_DIV_R: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - 7'd1;
					else if (state_q == ST_DIV_G)
						gain_q <= dvd_q[AVG_W-1:0];
					else if (state_q == ST_DIV_L)
						loss_q <= dvd_q[AVG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					up_q        <= up;
					down_q      <= down;
					res_rsi_q   <= '0;
					res_valid_q <= 1'b0;
				end
			end
			ST_PREP_G, ST_PREP_L: begin
				dvd_q <= first_q ? first_dvd : smooth_dvd;
				rem_q <= '0;
				div_q <= REM_W'(p_eff);
			end
			ST_PREP_R: begin
				res_valid_q <= 1'b1;
				res_rsi_q   <= RSI_FULL;
				dvd_q       <= {rsi_prod[RSI_W-1:0], 50'd0};
				rem_q       <= {1'b0, rsi_prod[61:RSI_W]};
				div_q       <= rsi_sum;
			end
			ST_DIV_G, ST_DIV_L, ST_DIV_R: begin
				if (cnt_q != '0) begin
					rem_q <= take ? trial[REM_W-1:0] : shifted[REM_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], take};
				end else if (state_q == ST_DIV_R) begin
					res_rsi_q <= dvd_q[RSI_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUTPUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUTPUT && out_free) begin
			rsi_out_q       <= res_rsi_q;
			rsi_valid_out_q <= res_valid_q;
		end
	end

	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rsi_hundredths <= RSI_FULL)
		else $error("rsi result above full scale");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rsi_valid |-> rsi_hundredths == '0)
		else $error("warm-up result not zero");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ss_q <= 9'd256)
		else $error("sample count past saturation");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_G || state_q == ST_DIV_L || state_q == ST_DIV_R)
		|-> rem_q < div_q)
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: tb/tb_wilder_rsi_indicator_unit.sv
// Self-checking testbench for wilder_rsi_indicator_unit: price transfers in, RSI results out.
// A directed table and random trend streams are checked against a built-in Wilder RSI predictor,
// but typed rows give their own results. Depends on wrsi_pkg and wilder_rsi_indicator_unit.
`timescale 1ns / 100ps

module tb_wilder_rsi_indicator_unit;
	import wrsi_pkg::*;

	localparam logic [2:0] ADDR_PERIOD = 3'(4 * REG_PERIOD);
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam logic [63:0] AVG_MASK   = (64'd1 << AVG_W) - 64'd1;
	localparam int TOTAL_ITEMS = 1550;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int DIR_ROWS = 23;

	typedef enum logic {DO_PRICE, DO_WRITE} step_kind_t;
	typedef enum int {TREND_MIXED, TREND_RISE, TREND_FALL} trend_t;

	typedef struct packed {
		logic [RSI_W-1:0] rsi;
		logic             valid;
	} rsi_expect_t;

	typedef struct packed {
		step_kind_t       kind;
		logic [2:0]       addr;
		logic [31:0]      value;
		logic             typed;
		logic [RSI_W-1:0] rsi;
		logic             valid;
	} dir_step_t;

	localparam dir_step_t DIRECTED [DIR_ROWS] = '{
		'{DO_PRICE, ADDR_PERIOD, 32'h0000_0000, 1'b1, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'hFFFF_FFFF, 1'b1, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h0000_0000, 1'b1, 14'd0, 1'b0},
		'{DO_WRITE, ADDR_PERIOD, 32'h0000_0001, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h8000_0000, 1'b1, RSI_FULL, 1'b1},
		'{DO_PRICE, ADDR_PERIOD, 32'h8000_0000, 1'b1, RSI_FULL, 1'b1},
		'{DO_PRICE, ADDR_PERIOD, 32'h0000_0000, 1'b1, 14'd0, 1'b1},
		'{DO_PRICE, ADDR_PERIOD, 32'h0000_0001, 1'b1, RSI_FULL, 1'b1},
		'{DO_WRITE, ADDR_PERIOD, 32'hFFFF_FF00, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'hFFFF_FFFF, 1'b1, RSI_FULL, 1'b1},
		'{DO_PRICE, ADDR_PERIOD, 32'h1234_5678, 1'b1, 14'd0, 1'b1},
		'{DO_WRITE, ADDR_UNUSED, 32'h0000_0003, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h1234_5679, 1'b1, RSI_FULL, 1'b1},
		'{DO_WRITE, ADDR_PERIOD, 32'h0000_0003, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h2000_0000, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h1000_0000, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h3000_0000, 1'b0, 14'd0, 1'b0},
		'{DO_WRITE, ADDR_PERIOD, 32'h0000_0002, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h0001_0000, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h0002_0000, 1'b0, 14'd0, 1'b0},
		'{DO_WRITE, ADDR_PERIOD, 32'h0000_00FF, 1'b0, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'hFFFF_0000, 1'b1, 14'd0, 1'b0},
		'{DO_PRICE, ADDR_PERIOD, 32'h0000_0000, 1'b1, 14'd0, 1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [PRICE_W-1:0] price;
	logic               out_valid;
	logic               out_ready;
	logic [RSI_W-1:0]   rsi_hundredths;
	logic               rsi_valid;

	logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
	logic [PRICE_W-1:0]  prev_px = '0;
	logic [AVG_W-1:0]    gain_avg = '0;
	logic [AVG_W-1:0]    loss_avg = '0;
	logic [COUNT_W-1:0]  px_count = '0;

	rsi_expect_t rsi_pending [$];
	int          fail_count = 0;
	int          items_sent = 0;
	int          idle_cycles = 0;
	bit          steady = 1'b0;
	logic [31:0] last_px = '0;

	wilder_rsi_indicator_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.price          (price),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rsi_hundredths (rsi_hundredths),
		.rsi_valid      (rsi_valid)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [RSI_W-1:0] rsi_ratio(input logic [63:0] g, input logic [63:0] l);
		if (l == 64'd0)
			return RSI_FULL;
		return RSI_W'((64'd10000 * g) / (g + l));
	endfunction

	task automatic wilder_predict(input logic [31:0] px, output rsi_expect_t want);
		logic [63:0] p;
		logic [63:0] up;
		logic [63:0] down;
		logic [63:0] g;
		logic [63:0] l;
		p = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
		up = 64'd0;
		down = 64'd0;
		if (px >= prev_px)
			up = 64'(px) - 64'(prev_px);
		else
			down = 64'(prev_px) - 64'(px);
		g = 64'(gain_avg);
		l = 64'(loss_avg);
		want = '0;
		if (px_count == '0) begin
			px_count = COUNT_W'(1);
		end else if (64'(px_count) <= p) begin
			g = (g + up) & AVG_MASK;
			l = (l + down) & AVG_MASK;
			if (64'(px_count) == p) begin
				g = ((g << 16) / p) & AVG_MASK;
				l = ((l << 16) / p) & AVG_MASK;
				want.rsi = rsi_ratio(g, l);
				want.valid = 1'b1;
			end
			px_count = px_count + COUNT_W'(1);
		end else begin
			g = ((g * (p - 64'd1) + (up << 16)) / p) & AVG_MASK;
			l = ((l * (p - 64'd1) + (down << 16)) / p) & AVG_MASK;
			want.rsi = rsi_ratio(g, l);
			want.valid = 1'b1;
			px_count = COUNT_W'(p + 64'd1);
		end
		gain_avg = g[AVG_W-1:0];
		loss_avg = l[AVG_W-1:0];
		prev_px = px;
	endtask

	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] next_price(input logic [31:0] from, input trend_t trend);
		int          r;
		logic [31:0] step;
		bit          rise;
		r = $urandom_range(0, 99);
		step = $urandom_range(0, 32'h0010_0000);
		rise = (trend == TREND_RISE) ? 1'b1 :
			(trend == TREND_FALL) ? 1'b0 : 1'($urandom_range(0, 1));
		if (r < 70)
			return rise ? from + step : from - step;
		if (r < 80)
			return $urandom();
		if (r < 88)
			return from;
		if (r < 94)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		return 32'($urandom_range(0, 255)) << 16;
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period(input int phase);
		int r;
		case (phase)
			0: return 8'd255;
			1: return 8'd1;
			2: return 8'd0;
			3: return 8'd2;
			default: begin
				r = $urandom_range(0, 9);
				if (r < 3)
					return 8'($urandom_range(1, 5));
				if (r < 8)
					return 8'($urandom_range(6, 30));
				if (r < 9)
					return 8'($urandom_range(1, 254));
				return PERIOD_RESET;
			end
		endcase
	endfunction

	task automatic flag(input string what);
		if (fail_count < MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic enqueue_result(input rsi_expect_t want);
		rsi_pending.insert(rsi_pending.size(), want);
	endtask

	task automatic send_price(input logic [31:0] px, input logic typed, input rsi_expect_t typed_want);
		int          gap;
		rsi_expect_t want;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		price <= px;
		do @(posedge clk); while (!in_ready);
		wilder_predict(px, want);
		if (typed)
			want = typed_want;
		enqueue_result(want);
		items_sent++;
		last_px = px;
	endtask

	// drop valid, then wait for every pending result
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rsi_pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		logic [31:0] rd_want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_PERIOD)
			cfg_period = data[PERIOD_W-1:0];
		@(negedge clk);
		rd_want = (addr == ADDR_PERIOD) ? {24'd0, cfg_period} : 32'd0;
		if (prdata !== rd_want)
			flag($sformatf("register read mismatch: expected %0h, got %0h", rd_want, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(posedge clk) begin
		rsi_expect_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rsi_pending.size() == 0) begin
				flag($sformatf("unexpected result rsi=%0d valid=%0b", rsi_hundredths, rsi_valid));
			end else begin
				want = rsi_pending.pop_front();
				if (rsi_hundredths !== want.rsi || rsi_valid !== want.valid)
					flag($sformatf("result mismatch: expected rsi=%0d valid=%0b, got rsi=%0d valid=%0b",
						want.rsi, want.valid, rsi_hundredths, rsi_valid));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** wilder_rsi_indicator_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	initial begin
		int             phase;
		int             len;
		int             i;
		logic [7:0]     per;
		logic [31:0]    word;
		trend_t         trend;
		rsi_expect_t    want;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		price = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == DO_WRITE) begin
				settle_idle();
				write_reg(DIRECTED[i].addr, DIRECTED[i].value);
			end else begin
				want.rsi = DIRECTED[i].rsi;
				want.valid = DIRECTED[i].valid;
				send_price(DIRECTED[i].value, DIRECTED[i].typed, want);
			end
		end

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			per = pick_period(phase);
			len = (per >= 8'd200) ? int'(per) + 40 : $urandom_range(30, 100);
			trend = trend_t'($urandom_range(0, 2));
			settle_idle();
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				write_reg(ADDR_UNUSED, $urandom());
			word = $urandom();
			word[PERIOD_W-1:0] = per;
			write_reg(ADDR_PERIOD, word);
			for (i = 0; i < len && items_sent < TOTAL_ITEMS; i++)
				send_price(next_price(last_px, trend), 1'b0, '0);
			phase++;
		end

		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && rsi_pending.size() == 0)
			$display("** wilder_rsi_indicator_unit: PASSED **");
		else
			$display("** wilder_rsi_indicator_unit: FAILED **");
		$finish;
	end

endmodule
